@@ rtl/core/polynomial_newton_root_finder_defines.svh @@
// Assertion macros for the polynomial root finder.
`ifndef POLYNOMIAL_NEWTON_ROOT_FINDER_DEFINES_SVH
`define POLYNOMIAL_NEWTON_ROOT_FINDER_DEFINES_SVH
// Implication checked at every rising edge outside reset.
`define PNR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PNR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/pnrf_pkg.sv @@
// ----------------------------------------------------------------------------
// pnrf_pkg
// Types and constants shared by the polynomial root finder modules.
// ----------------------------------------------------------------------------
`default_nettype none
package pnrf_pkg;
  localparam int unsigned FUNC_W = 2;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_EVAL = 2'd1,
    FUNC_ROOT = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FLAT  = 2'd1,
    ST_LIMIT = 2'd2
  } status_t;

  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_TOL   = 2'd1;
  localparam logic [1:0] CFG_ITER  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         coef_index;
    logic signed [31:0] operand_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [7:0]         iterations_used;
  } out_beat_t;

  // Divider request/response between sequencer and divider.
  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/pnrf_div.sv @@
// ----------------------------------------------------------------------------
// pnrf_div
// Serial signed divider: (num * 2^FRAC_BITS) / den, truncating toward zero,
// saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pnrf_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  pnrf_pkg::div_req_t     req,
  output pnrf_pkg::div_rsp_t     rsp
);
  import pnrf_pkg::*;
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [NW:0]   rem_r, rem_nxt;
  logic [31:0]   den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic          done_r, done_nxt;
  logic signed [31:0] q_r, q_nxt;
  logic [NW:0]   trial;
  logic [NW:0]   shifted;
  logic signed [NW+1:0] sq;

  always_comb begin
    busy_nxt = busy_r; cnt_nxt = cnt_r; num_nxt = num_r; rem_nxt = rem_r;
    den_nxt = den_r; neg_nxt = neg_r; done_nxt = 1'b0; q_nxt = q_r;
    shifted = {rem_r[NW-1:0], num_r[NW-1]};
    trial   = shifted - {{(NW-31){1'b0}}, den_r};
    sq      = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      num_nxt  = NW'(req.num[31] ? -{{FRAC_BITS{req.num[31]}}, req.num} :
                     {{FRAC_BITS{1'b0}}, req.num}) << FRAC_BITS;
      den_nxt  = req.den[31] ? 32'(-req.den) : req.den;
      neg_nxt  = req.num[31] ^ req.den[31];
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!trial[NW]) begin
        rem_nxt = trial;
        num_nxt = {num_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        num_nxt = {num_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        sq = neg_r ? -$signed({2'b00, num_nxt}) : $signed({2'b00, num_nxt});
        q_nxt = sat32(66'(sq));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
    neg_r <= neg_nxt; q_r <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
endmodule
`default_nettype wire

@@ rtl/core/polynomial_newton_root_finder.sv @@
// ----------------------------------------------------------------------------
// polynomial_newton_root_finder
// Newton-Raphson polynomial root finder with a Horner evaluator over a
// coefficient memory, signed fixed point with saturation.
// ----------------------------------------------------------------------------
//  Channel | Direction | Beat contents
//  in_     | input     | func, coef_index, operand_value
//  out_    | output    | result_value, status, iterations_used
//  cfg_    | input     | register index and write data
//
// A load is written at its accepting edge, so loads can follow back to back.
// An evaluation holds the input after its accepting edge while each Horner
// step reads one coefficient from the memory in S_RD, then multiplies and
// adds in S_MAC, until S_OUT hands the beat over.
// A Newton iteration walks the memory once (p and p' share the reads), makes
// a check in S_CHECK, waits on the serial divider in S_DIV and takes a step
// in S_STEP. After reset a clearing pass over all MAX_COEFFS entries zeroes
// the memory while no beat is taken. A stalled result holds in the output
// register; a new beat may be taken meanwhile, but its result waits in the
// hand-over state until the register is free.
`default_nettype none
`include "polynomial_newton_root_finder_defines.svh"
module polynomial_newton_root_finder #(
  parameter int MAX_COEFFS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  pnrf_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output pnrf_pkg::out_beat_t  out_data,
  input  wire                  cfg_we,
  input  wire [1:0]            cfg_index,
  input  wire [30:0]           cfg_wdata
);
  import pnrf_pkg::*;
  localparam int AW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int NW = $clog2(MAX_COEFFS + 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_RD    = 8'b00000100,
    S_MAC   = 8'b00001000,
    S_CHECK = 8'b00010000,
    S_DIV   = 8'b00100000,
    S_STEP  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  // Configuration registers.
  logic [4:0]  count_r;
  logic [30:0] tol_r;
  logic [7:0]  maxit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 5'd1;
      tol_r   <= 31'd66;
      maxit_r <= 8'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT: count_r <= cfg_wdata[4:0];
        CFG_TOL:   tol_r   <= cfg_wdata;
        CFG_ITER:  maxit_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Coefficients in use, clamped to 1..MAX_COEFFS.
  logic [NW-1:0] n_used;
  always_comb begin
    if (count_r == 5'd0) n_used = NW'(1);
    else if (32'(count_r) > MAX_COEFFS) n_used = NW'(MAX_COEFFS);
    else n_used = NW'(count_r);
  end

  // Coefficient memory, one write and one read port, registered read.
  logic signed [31:0] mem [MAX_COEFFS];
  logic               mem_we;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic signed [31:0] mem_wd, mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

  state_t             state_r, state_nxt;
  logic [NW-1:0]      idx_r, idx_nxt;       // count of coefficients left
  logic [AW-1:0]      clr_r, clr_nxt;
  logic               root_r, root_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] p_r, p_nxt;
  logic signed [31:0] d_r, d_nxt;
  logic [7:0]         it_r, it_nxt;
  logic [1:0]         st_r, st_nxt;
  logic               ov_r, ov_nxt;
  out_beat_t          od_r, od_nxt;
  div_req_t           dreq;
  div_rsp_t           drsp;

  pnrf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp)
  );

  // Horner datapath: coefficient index k = idx_r-1 was read last cycle.
  logic signed [63:0] pm, dm;
  logic signed [31:0] pmul, dmul, dk, p_step, d_step;
  logic signed [39:0] kc;
  logic [NW-1:0]      kpow;
  logic signed [32:0] afp;
  logic signed [32:0] nxt_full, diff;
  logic signed [31:0] nxt_x;

  always_comb begin
    pm     = 64'(p_r) * 64'(x_r);
    dm     = 64'(d_r) * 64'(x_r);
    pmul   = sat32(66'(pm >>> FRAC_BITS));
    dmul   = sat32(66'(dm >>> FRAC_BITS));
    p_step = sat32(66'(pmul) + 66'(mem_rd_r));
    kpow   = idx_r - NW'(1);
    kc     = 40'(mem_rd_r) * $signed({1'b0, 7'(kpow)});
    dk     = sat32(66'(kc));
    d_step = sat32(66'(dmul) + 66'(dk));
    afp    = d_r[31] ? -33'(d_r) : 33'(d_r);
    nxt_full = 33'(x_r) - 33'(drsp.quot);
    nxt_x  = sat32(66'(nxt_full));
    diff   = 33'(nxt_x) - 33'(x_r);
    if (diff < 0) diff = -diff;
  end

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; clr_nxt = clr_r; root_nxt = root_r;
    x_nxt = x_r; p_nxt = p_r; d_nxt = d_r; it_nxt = it_r; st_nxt = st_r;
    ov_nxt = ov_r; od_nxt = od_r;
    mem_we = 1'b0; mem_wa = clr_r; mem_wd = '0; mem_ra = '0;
    dreq = '0;
    in_stall = !(state_r == S_IDLE);
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == MAX_COEFFS - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          x_nxt = in_data.operand_value;
          case (in_data.func)
            FUNC_LOAD: begin
              mem_we = 32'(in_data.coef_index) < MAX_COEFFS;
              mem_wa = AW'(in_data.coef_index);
              mem_wd = in_data.operand_value;
            end
            FUNC_EVAL: begin
              root_nxt = 1'b0; it_nxt = '0; st_nxt = ST_DONE;
              p_nxt = '0; d_nxt = '0; idx_nxt = n_used; state_nxt = S_RD;
            end
            FUNC_ROOT: begin
              root_nxt = 1'b1; it_nxt = '0; st_nxt = ST_LIMIT;
              p_nxt = '0; d_nxt = '0; idx_nxt = n_used;
              state_nxt = (maxit_r == 8'd0) ? S_OUT : S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        mem_ra = AW'(idx_r - NW'(1));
        state_nxt = S_MAC;
      end
      S_MAC: begin
        p_nxt = p_step;
        if (idx_r > NW'(1)) d_nxt = d_step;
        idx_nxt = idx_r - NW'(1);
        if (idx_r == NW'(1)) state_nxt = root_r ? S_CHECK : S_OUT;
        else state_nxt = S_RD;
        if (idx_r == NW'(1) && !root_r) x_nxt = p_step;
      end
      S_CHECK: begin
        it_nxt = it_r + 8'd1;
        if (d_r == 32'sd0 || afp < 33'(tol_r)) begin
          st_nxt = ST_FLAT; state_nxt = S_OUT;
        end else begin
          dreq.start = 1'b1; dreq.num = p_r; dreq.den = d_r;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (drsp.done) state_nxt = S_STEP;
      end
      S_STEP: begin
        x_nxt = nxt_x;
        if (diff < 33'(tol_r)) begin
          st_nxt = ST_DONE; state_nxt = S_OUT;
        end else if (it_r == maxit_r) begin
          state_nxt = S_OUT;
        end else begin
          p_nxt = '0; d_nxt = '0; idx_nxt = n_used; state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt.result_value = x_r;
          od_nxt.status = st_r;
          od_nxt.iterations_used = root_r ? (st_r == ST_LIMIT ? maxit_r : it_r) : 8'd0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r <= idx_nxt; root_r <= root_nxt; x_r <= x_nxt; p_r <= p_nxt;
    d_r <= d_nxt; it_r <= it_nxt; st_r <= st_nxt; od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  `PNR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `PNR_ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_r != S_IDLE, in_stall, "beat taken while busy")
  `PNR_ASSERT_IMPL(a_eval_iters, clk, rst_n, out_valid && out_data.status == ST_FLAT, out_data.iterations_used != 8'd0, "flat result with no iteration")
endmodule
`default_nettype wire

@@ tb/tb_polynomial_newton_root_finder.sv @@
// ----------------------------------------------------------------------------
// tb_polynomial_newton_root_finder
// Self-checking testbench for the Newton-Raphson polynomial root finder.
// ----------------------------------------------------------------------------
// A predictor in this file follows every accepted input beat and keeps its
// own copy of the coefficient store and registers. It computes each expected
// evaluation or root beat. A checker compares every result beat, field by
// field, with the oldest expectation. Directed tests cover the field
// extremes, saturation and every way a root search can stop. A back-pressure
// test holds the receiver off for one long stretch. Random phases then load
// whole polynomials and evaluate them or seek roots, with idle gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_polynomial_newton_root_finder;
  import pnrf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_COUNT;
  logic [30:0] cfg_wdata = '0;

  polynomial_newton_root_finder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Predictor state: the block's coefficient store and registers as we
  // believe them to be after every accepted beat and register write.
  int          coef_mem [16];
  logic [4:0]  coef_count;
  logic [30:0] tol_q;
  logic [7:0]  iter_limit;

  out_beat_t   pending_results[$];
  int          error_count = 0;
  int          items_sent = 0;
  int          evals_seen = 0;
  int          roots_seen = 0;
  int          status_seen [3] = '{0, 0, 0};
  int          idle_mode = 0;     // 0: sender sparse gaps, 1: receiver sparse, 2: none
  int          hold_cycles = 0;
  bit          offering = 1'b0;

  // Saturate a wide value into signed 32 bits.
  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // Q16.16 product, floored then saturated.
  function automatic int q_mul(int a, int b);
    return clamp32((longint'(a) * longint'(b)) >>> 16);
  endfunction

  function automatic int live_count();
    if (coef_count == 0) return 1;
    if (coef_count > 16) return 16;
    return coef_count;
  endfunction

  function automatic int poly_value(int x);
    int acc;
    acc = 0;
    for (int i = live_count(); i > 0; i--)
      acc = clamp32(longint'(q_mul(acc, x)) + coef_mem[i-1]);
    return acc;
  endfunction

  // Derivative by Horner's rule over the saturated coefficients i*c_i.
  function automatic int slope_value(int x);
    int acc;
    int d;
    acc = 0;
    for (int i = live_count(); i > 1; i--) begin
      d = clamp32(longint'(i - 1) * longint'(coef_mem[i-1]));
      acc = clamp32(longint'(q_mul(acc, x)) + d);
    end
    return acc;
  endfunction

  // Works out the result of one accepted beat, if it has one, and updates
  // the coefficient store for loads.
  function automatic void forecast_beat(in_beat_t b);
    out_beat_t r;
    int        g, f, fp, nx;
    longint    step, diff, afp;
    r = '0;
    case (func_t'(b.func))
      FUNC_LOAD: begin
        coef_mem[b.coef_index] = b.operand_value;
        return;
      end
      FUNC_EVAL: begin
        r.result_value = poly_value(b.operand_value);
        r.status = ST_DONE;
      end
      FUNC_ROOT: begin
        g = b.operand_value;
        r.status = ST_LIMIT;
        r.iterations_used = iter_limit;
        for (int it = 0; it < iter_limit; it++) begin
          f = poly_value(g);
          fp = slope_value(g);
          afp = (fp < 0) ? -longint'(fp) : longint'(fp);
          // A zero slope stops the search even when the tolerance is zero.
          if (fp == 0 || afp < longint'(tol_q)) begin
            r.status = ST_FLAT;
            r.iterations_used = it + 1;
            break;
          end
          step = (longint'(f) * 64'sd65536) / longint'(fp);
          nx = clamp32(longint'(g) - longint'(clamp32(step)));
          diff = longint'(nx) - longint'(g);
          if (diff < 0) diff = -diff;
          g = nx;
          if (diff < longint'(tol_q)) begin
            r.status = ST_DONE;
            r.iterations_used = it + 1;
            break;
          end
        end
        r.result_value = g;
      end
      default: return;
    endcase
    pending_results.push_back(r);
  endfunction

  // Result checker. Sampling just after the edge sees the values that the
  // block and the stall process held at that edge.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: actual %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.result_value !== out_data.result_value ||
            want.status !== out_data.status ||
            want.iterations_used !== out_data.iterations_used) begin
          $display("%0t: mismatch: expected value %h status %0d iterations %0d",
                   $time, want.result_value, want.status, want.iterations_used);
          $display("%0t:           actual value %h status %0d iterations %0d",
                   $time, out_data.result_value, out_data.status, out_data.iterations_used);
          error_count++;
        end
        if (want.iterations_used == 0 && want.status == ST_DONE) begin
          evals_seen++;
        end else begin
          roots_seen++;
          if (want.status < 3) status_seen[want.status]++;
        end
      end
    end
  end

  // Receiver stall pattern; a long hold-off counts itself down here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      case (idle_mode)
        0: out_stall <= ($urandom_range(99) < 53);
        1: out_stall <= ($urandom_range(99) < 6);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Offers one beat and returns at the edge where it is taken. Valid stays
  // high unless a gap is drawn, so back-to-back beats are not split.
  task automatic send_beat(func_t fn, logic [3:0] idx, int val);
    in_beat_t b;
    int       pct;
    b.func = fn;
    b.coef_index = idx;
    b.operand_value = val;
    in_valid <= 1'b1;
    in_data <= b;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    forecast_beat(b);
    if (fn != FUNC_NONE) items_sent++;
    pct = (idle_mode == 0) ? 6 : (idle_mode == 1) ? 53 : 0;
    if ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drains the block before a register write. Loads and ignored beats give
  // no result, so a further wait covers one still in progress.
  task automatic wait_idle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COUNT: coef_count = val[4:0];
      CFG_TOL:   tol_q = val;
      CFG_ITER:  iter_limit = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [4:0] cnt, logic [30:0] tol, logic [7:0] iters);
    write_reg(CFG_COUNT, 31'(cnt));
    write_reg(CFG_TOL, tol);
    write_reg(CFG_ITER, 31'(iters));
  endtask

  // Field extremes, saturation in evaluation, every function code, and the
  // clamping of the coefficient count.
  task automatic test_eval_extremes();
    send_beat(FUNC_EVAL, 4'd0, 0);                     // empty store after reset
    send_beat(FUNC_ROOT, 4'd15, 32'sh00050000);        // constant polynomial is flat
    set_regs(5'd3, 31'd66, 8'd100);
    send_beat(FUNC_LOAD, 4'd0, -32'sh00020000);        // x^2 - 2
    send_beat(FUNC_LOAD, 4'd1, 0);
    send_beat(FUNC_LOAD, 4'd2, 32'sh00010000);
    send_beat(FUNC_EVAL, 4'd0, 32'sh7fffffff);
    send_beat(FUNC_EVAL, 4'd0, 32'sh80000000);
    send_beat(FUNC_EVAL, 4'd0, 32'sh00018000);
    send_beat(FUNC_NONE, 4'd7, 32'sh12345678);        // unused code, no result
    send_beat(FUNC_LOAD, 4'd15, 32'sh80000000);
    send_beat(FUNC_LOAD, 4'd14, 32'sh7fffffff);
    write_reg(CFG_COUNT, 31'd0);                       // behaves as one coefficient
    send_beat(FUNC_EVAL, 4'd0, 32'sh00030000);
    write_reg(CFG_COUNT, 31'd31);                      // behaves as the full store
    send_beat(FUNC_EVAL, 4'd0, 32'sh00010000);
    send_beat(FUNC_EVAL, 4'd0, -32'sh00010000);
    for (int i = 3; i < 16; i++) send_beat(FUNC_LOAD, 4'(i), 0);
  endtask

  // Each way a Newton search can end.
  task automatic test_root_stops();
    set_regs(5'd3, 31'd66, 8'd100);
    send_beat(FUNC_ROOT, 4'd0, 32'sh00010000);         // converges towards sqrt 2
    send_beat(FUNC_ROOT, 4'd0, 0);                     // zero slope at the start
    write_reg(CFG_ITER, 31'd0);
    send_beat(FUNC_ROOT, 4'd0, 32'sh00030000);         // guess returned untouched
    write_reg(CFG_ITER, 31'd2);
    send_beat(FUNC_ROOT, 4'd0, 32'sh00640000);         // runs out of iterations
    write_reg(CFG_TOL, 31'h7fffffff);
    send_beat(FUNC_ROOT, 4'd0, 32'sh00020000);         // slope below the threshold
    set_regs(5'd3, 31'd0, 8'd255);
    send_beat(FUNC_ROOT, 4'd0, 32'sh00010000);         // zero tolerance: only a zero slope or the limit stops
    write_reg(CFG_COUNT, 31'd16);
    send_beat(FUNC_ROOT, 4'd0, 32'sh7fffffff);
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so the
  // result register fills and the input stalls.
  task automatic test_backpressure();
    set_regs(5'd3, 31'd66, 8'd20);
    hold_cycles = 600;
    for (int i = 0; i < 10; i++)
      send_beat((i % 3 == 0) ? FUNC_ROOT : FUNC_EVAL, 4'd0,
                int'($urandom_range(32'h40000)) - 32'sh20000);
  endtask

  function automatic int small_q();
    return int'($urandom_range(32'h60000)) - 32'sh30000;
  endfunction

  // Random phases: each picks a register setting, loads a whole polynomial
  // and then evaluates it or searches for roots, with some noise mixed in.
  task automatic test_random_polys();
    int         cnt;
    int         r;
    logic [3:0] idx;
    while (items_sent < 1050) begin
      idle_mode = (items_sent < 370) ? 0 : (items_sent < 710) ? 1 : 2;
      r = $urandom_range(9);
      cnt = (r == 0) ? 16 : (r == 1) ? 0 : $urandom_range(1, 6);
      r = $urandom_range(9);
      set_regs(5'(cnt),
               (r == 0) ? 31'h7fffffff : (r == 1) ? 31'd0 : 31'($urandom_range(2000)),
               (r == 2) ? 8'd0 : 8'($urandom_range(1, 12)));
      for (int i = 0; i < live_count(); i++)
        send_beat(FUNC_LOAD, 4'(i), ($urandom_range(7) == 0) ? int'($urandom) : small_q());
      repeat ($urandom_range(4, 12)) begin
        r = $urandom_range(19);
        idx = 4'($urandom);
        if (r == 0) send_beat(FUNC_NONE, idx, int'($urandom));
        else if (r == 1) send_beat(FUNC_LOAD, idx, int'($urandom));
        else if (r < 9)
          send_beat(FUNC_EVAL, idx, ($urandom_range(3) == 0) ? int'($urandom) : small_q());
        else
          send_beat(FUNC_ROOT, idx, ($urandom_range(5) == 0) ? int'($urandom) : small_q());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) coef_mem[i] = 0;
    coef_count = 5'd1;
    tol_q = 31'd66;
    iter_limit = 8'd100;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_eval_extremes();
    test_root_stops();
    test_backpressure();
    test_random_polys();
    idle_mode = 2;
    wait_idle();
    repeat (100) @(posedge clk);
    $display("Covered %0d input beats: %0d evaluations and %0d root searches checked.",
             items_sent, evals_seen, roots_seen);
    $display("Root outcomes: %0d converged, %0d flat, %0d out of iterations.",
             status_seen[0], status_seen[1], status_seen[2]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_polynomial_newton_root_finder: clean");
    end else begin
      $display("tb_polynomial_newton_root_finder: errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #240000000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("tb_polynomial_newton_root_finder: errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/pnrf_pkg.sv
rtl/core/pnrf_div.sv
rtl/core/polynomial_newton_root_finder.sv
tb/tb_polynomial_newton_root_finder.sv
